@@ hdl/bwl_pkg.sv @@
// ----------------------------------------------------------------------------
// bwl_pkg
// Shared widths, constants, state encoding and the command/status bundles
// between the bandwidth limiter's controller and datapath.
// ----------------------------------------------------------------------------
package bwl_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int NOW_W    = 48;
    localparam int BYTES_W  = 31;
    localparam int SLEEP_W  = 32;
    localparam int WTIME_W  = 40;
    localparam int WBYTES_W = 48;
    localparam int WSLEEP_W = 40;
    localparam int CREDIT_W = 64;
    localparam int CFG_W    = 32;

    localparam logic [19:0]      ONE_SECOND_US = 20'd1000000;
    localparam logic [6:0]       MIN_GAP_US    = 7'd100;
    localparam logic [6:0]       MIN_SLEEP_US  = 7'd100;
    localparam logic [CFG_W-1:0] BACKLOG_RESET = 32'd10000000;

    localparam logic [6:0] DIV_STEPS_SLEEP = 7'd32;

    // one second split as 2^6 * 15625; the odd part is removed a 16-bit digit
    // at a time by multiplying with its reciprocal scaled by 2^44
    localparam logic [13:0] ONE_SECOND_ODD   = 14'd15625;
    localparam logic [31:0] ONE_SECOND_RECIP = 32'd1125899907;
    localparam logic [3:0]  EARN_STEPS       = 4'd8;

    // register index, taken from paddr[2]
    localparam logic REG_RATE_LIMIT    = 1'b0;
    localparam logic REG_BACKLOG_LIMIT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RESYNC,
        ST_DEBIT,
        ST_MUL_EARN,
        ST_EARN_GO,
        ST_EARN_WAIT,
        ST_ADD_EARN,
        ST_CMP_CAP,
        ST_MUL_DLO,
        ST_MUL_DHI,
        ST_DSUM,
        ST_SLEEP_GO,
        ST_SLEEP_WAIT,
        ST_SLEEP_SET,
        ST_PUSH_ACC,
        ST_PUSH_ROT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_GAP_RATE,
        MUL_CAP,
        MUL_DEF_LO,
        MUL_DEF_HI
    } mul_sel_t;

    typedef enum logic {
        DIV_EARN,
        DIV_SLEEP
    } div_mode_t;

    typedef struct packed {
        logic      in_load;
        logic      gap_load;
        logic      resync;
        logic      debit;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      div_start;
        div_mode_t div_mode;
        logic      add_earn;
        logic      cap_load;
        logic      deficit_load;
        logic      dlo_save;
        logic      dsum;
        logic      sleep_set;
        logic      push_acc;
        logic      slot_rotate;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic idle_evt;
        logic resync_need;
        logic gap_short;
        logic cap_over;
        logic credit_neg;
        logic div_busy;
        logic acc_over;
    } status_t;

endpackage

@@ hdl/bwl_ram.sv @@
// ----------------------------------------------------------------------------
// bwl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/bwl_div.sv @@
// ----------------------------------------------------------------------------
// bwl_div
// Restoring serial divider, one quotient bit per cycle. The remainder is
// preloaded so that a long dividend can be finished with fewer steps.
// ----------------------------------------------------------------------------
module bwl_div
    import bwl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [6:0]  steps,
    input  logic [31:0] rem_init,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        busy
);

    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] sh_reg, sh_next;
    logic [31:0] div_reg;
    logic [33:0] trial;
    logic        ge;

    // shift the next dividend bit into the remainder and try the subtract
    assign trial = {1'b0, rem_reg, sh_reg[63]} - {2'b00, div_reg};
    assign ge    = ~trial[33];

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        sh_next  = sh_reg;
        if (start) begin
            cnt_next = steps;
            rem_next = rem_init;
            sh_next  = dividend;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 7'd1;
            rem_next = ge ? trial[31:0] : {rem_reg[30:0], sh_reg[63]};
            sh_next  = {sh_reg[62:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = sh_reg;

endmodule

@@ hdl/bwl_dp.sv @@
// ----------------------------------------------------------------------------
// bwl_dp
// Datapath: credit arithmetic, shared multiplier, reciprocal earn divider,
// serial sleep divider and the one-second slot ring with its window sums.
// ----------------------------------------------------------------------------
module bwl_dp
    import bwl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [CFG_W-1:0]    rate_limit,
    input  logic [CFG_W-1:0]    backlog_limit,
    input  logic [NOW_W-1:0]    s_now_us,
    input  logic [BYTES_W-1:0]  s_byte_count,
    output logic [SLEEP_W-1:0]  m_sleep_us,
    output logic [WTIME_W-1:0]  m_window_time,
    output logic [WBYTES_W-1:0] m_window_bytes,
    output logic [WSLEEP_W-1:0] m_window_sleep
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_W = WTIME_W + WBYTES_W + WSLEEP_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    // event and credit state
    logic [NOW_W-1:0]    now_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [NOW_W-1:0]    last_tick_reg;
    logic [CREDIT_W-1:0] credit_reg;
    logic [31:0]         gap_reg;
    logic [63:0]         prod_reg;
    logic [51:0]         dlo_reg;
    logic [83:0]         dprod_reg;
    logic [CREDIT_W-1:0] deficit_reg;
    logic                sat_reg;
    logic [SLEEP_W-1:0]  sleep_reg;

    // window state
    logic [WTIME_W-1:0]    acc_time_reg, sum_time_reg;
    logic [WBYTES_W-1:0]   acc_bytes_reg, sum_bytes_reg;
    logic [WSLEEP_W-1:0]   acc_sleep_reg, sum_sleep_reg;
    logic [IDX_W-1:0]      slot_index_reg;
    logic [SLOT_COUNT-1:0] slot_valid_reg;

    logic [NOW_W:0]      gap_full;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic [CREDIT_W:0]   debit_sum, earn_sum;
    logic [CREDIT_W-1:0] debit_val, earn_val;
    logic [SLEEP_W-1:0]  sleep_val;

    logic [31:0] div_rem_init, div_divisor;
    logic [63:0] div_dividend, div_q;
    logic [6:0]  div_steps;
    logic        div_start;
    logic        div_busy;

    // earn divider state
    logic [3:0]  earn_cnt_reg;
    logic [63:0] earn_x_reg;
    logic [13:0] earn_rem_reg;
    logic [63:0] earn_q_reg;
    logic [63:0] earn_p_reg;
    logic [29:0] earn_z;
    logic [15:0] earn_qd;
    logic [29:0] earn_qd_d;
    logic        earn_start;
    logic        earn_busy;

    logic [SLOT_W-1:0]   ram_rd, slot_rd;
    logic [WTIME_W-1:0]  slot_time;
    logic [WBYTES_W-1:0] slot_bytes;
    logic [WSLEEP_W-1:0] slot_sleep;

    // ---- status ----
    assign gap_full = {1'b0, now_reg} - {1'b0, last_tick_reg};

    always_comb begin
        status             = '0;
        status.idle_evt    = (bytes_reg == '0) || (rate_limit == '0);
        status.resync_need = gap_full[NOW_W] ||
                             (gap_full[NOW_W-1:0] > NOW_W'(backlog_limit));
        status.gap_short   = gap_reg < 32'(MIN_GAP_US);
        status.cap_over    = !credit_reg[CREDIT_W-1] && (credit_reg > prod_reg);
        status.credit_neg  = credit_reg[CREDIT_W-1];
        status.div_busy    = div_busy || earn_busy;
        status.acc_over    = acc_time_reg > WTIME_W'(ONE_SECOND_US);
    end

    // ---- shared 32x32 multiplier ----
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_GAP_RATE: begin
                mul_a = gap_reg;
                mul_b = rate_limit;
            end
            MUL_CAP: begin
                mul_a = backlog_limit;
                mul_b = rate_limit;
            end
            MUL_DEF_LO: begin
                mul_a = deficit_reg[31:0];
                mul_b = {12'd0, ONE_SECOND_US};
            end
            MUL_DEF_HI: begin
                mul_a = deficit_reg[63:32];
                mul_b = {12'd0, ONE_SECOND_US};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // ---- saturating credit arithmetic ----
    assign debit_sum = {credit_reg[CREDIT_W-1], credit_reg} - {34'd0, bytes_reg};
    assign debit_val = (debit_sum[CREDIT_W] != debit_sum[CREDIT_W-1]) ?
                       {1'b1, {(CREDIT_W-1){1'b0}}} : debit_sum[CREDIT_W-1:0];
    assign earn_sum  = {credit_reg[CREDIT_W-1], credit_reg} + {1'b0, earn_q_reg};
    assign earn_val  = (earn_sum[CREDIT_W] != earn_sum[CREDIT_W-1]) ?
                       {1'b0, {(CREDIT_W-1){1'b1}}} : earn_sum[CREDIT_W-1:0];

    // ---- earn divider: floor(prod / 1e6) as floor((prod >> 6) / 15625) ----
    assign earn_start = cmd.div_start && (cmd.div_mode == DIV_EARN);
    assign earn_busy  = (earn_cnt_reg != '0);
    assign earn_z     = {earn_rem_reg, earn_x_reg[63:48]};
    assign earn_qd    = earn_p_reg[59:44];
    assign earn_qd_d  = 30'(earn_qd) * 30'(ONE_SECOND_ODD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            earn_cnt_reg <= '0;
        end else if (earn_start) begin
            earn_cnt_reg <= EARN_STEPS;
        end else if (earn_busy) begin
            earn_cnt_reg <= earn_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (earn_start) begin
            earn_x_reg   <= {6'd0, prod_reg[63:6]};
            earn_rem_reg <= '0;
            earn_q_reg   <= '0;
        end else if (earn_busy) begin
            if (!earn_cnt_reg[0]) begin
                // estimate the digit quotient by the scaled reciprocal
                earn_p_reg <= 64'(earn_z) * 64'(ONE_SECOND_RECIP);
            end else begin
                // take the digit, keep the remainder, advance to the next digit
                earn_q_reg   <= {earn_q_reg[47:0], earn_qd};
                earn_rem_reg <= earn_z[13:0] - earn_qd_d[13:0];
                earn_x_reg   <= {earn_x_reg[47:0], 16'd0};
            end
        end
    end

    // ---- sleep divider ----
    assign div_start    = cmd.div_start && (cmd.div_mode == DIV_SLEEP);
    assign div_rem_init = dprod_reg[63:32];
    assign div_dividend = {dprod_reg[31:0], 32'd0};
    assign div_divisor  = rate_limit;
    assign div_steps    = DIV_STEPS_SLEEP;

    bwl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .busy     (div_busy)
    );

    assign sleep_val = sat_reg ? '1 : div_q[SLEEP_W-1:0];

    // ---- event registers ----
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            now_reg   <= s_now_us;
            bytes_reg <= s_byte_count;
            sleep_reg <= '0;
        end else if (cmd.sleep_set) begin
            // drop short sleeps
            sleep_reg <= (sleep_val <= SLEEP_W'(MIN_SLEEP_US)) ? '0 : sleep_val;
        end
        if (cmd.gap_load) begin
            gap_reg <= gap_full[31:0];
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.dlo_save) begin
            dlo_reg <= prod_reg[51:0];
        end
        if (cmd.dsum) begin
            dprod_reg <= {prod_reg[51:0], 32'd0} + {32'd0, dlo_reg};
        end
        if (cmd.deficit_load) begin
            deficit_reg <= '0 - credit_reg;
        end
        if (div_start) begin
            // quotient will not fit in 32 bits
            sat_reg <= (|dprod_reg[83:64]) || (dprod_reg[63:32] >= rate_limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_tick_reg <= '0;
            credit_reg    <= '0;
        end else begin
            priority if (cmd.resync) begin
                credit_reg    <= CREDIT_W'(bytes_reg);
                last_tick_reg <= now_reg;
            end else if (cmd.debit) begin
                credit_reg <= debit_val;
            end else if (cmd.add_earn) begin
                credit_reg    <= earn_val;
                last_tick_reg <= now_reg;
            end else if (cmd.cap_load) begin
                credit_reg <= prod_reg;
            end
        end
    end

    // ---- slot ring ----
    bwl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (cmd.slot_rotate),
        .wr_addr (slot_index_reg),
        .wr_data ({acc_time_reg, acc_bytes_reg, acc_sleep_reg}),
        .rd_addr (slot_index_reg),
        .rd_data (ram_rd)
    );

    // a slot never written since the last clear reads as zero
    assign slot_rd = slot_valid_reg[slot_index_reg] ? ram_rd : '0;
    assign {slot_time, slot_bytes, slot_sleep} = slot_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_time_reg   <= '0;
            acc_bytes_reg  <= '0;
            acc_sleep_reg  <= '0;
            sum_time_reg   <= '0;
            sum_bytes_reg  <= '0;
            sum_sleep_reg  <= '0;
            slot_index_reg <= '0;
            slot_valid_reg <= '0;
        end else begin
            priority if (cmd.resync) begin
                acc_time_reg   <= '0;
                acc_bytes_reg  <= '0;
                acc_sleep_reg  <= '0;
                sum_time_reg   <= '0;
                sum_bytes_reg  <= '0;
                sum_sleep_reg  <= '0;
                slot_index_reg <= '0;
                slot_valid_reg <= '0;
            end else if (cmd.push_acc) begin
                acc_time_reg  <= acc_time_reg + WTIME_W'(gap_reg);
                acc_bytes_reg <= acc_bytes_reg + WBYTES_W'(bytes_reg);
                acc_sleep_reg <= acc_sleep_reg + WSLEEP_W'(sleep_reg);
            end else if (cmd.slot_rotate) begin
                // retire the oldest slot and replace it with the accumulators
                sum_time_reg  <= sum_time_reg - slot_time + acc_time_reg;
                sum_bytes_reg <= sum_bytes_reg - slot_bytes + acc_bytes_reg;
                sum_sleep_reg <= sum_sleep_reg - slot_sleep + acc_sleep_reg;
                acc_time_reg  <= '0;
                acc_bytes_reg <= '0;
                acc_sleep_reg <= '0;
                slot_valid_reg[slot_index_reg] <= 1'b1;
                slot_index_reg <= (slot_index_reg == IDX_LAST) ? '0 :
                                  slot_index_reg + IDX_W'(1);
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_sleep_us     <= sleep_reg;
            m_window_time  <= sum_time_reg + acc_time_reg;
            m_window_bytes <= sum_bytes_reg + acc_bytes_reg;
            m_window_sleep <= sum_sleep_reg + acc_sleep_reg;
        end
    end

endmodule

@@ hdl/bwl_ctrl.sv @@
// ----------------------------------------------------------------------------
// bwl_ctrl
// Controller: sequences one transfer event through check, credit update,
// earn and sleep divisions, window update and result hand-off.
// ----------------------------------------------------------------------------
module bwl_ctrl
    import bwl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (status.idle_evt) begin
                    state_next = ST_DONE;
                end else if (status.resync_need) begin
                    state_next = ST_RESYNC;
                end else begin
                    state_next = ST_DEBIT;
                end
            end
            ST_RESYNC:   state_next = ST_DONE;
            ST_DEBIT: begin
                state_next = status.gap_short ? ST_PUSH_ACC : ST_MUL_EARN;
            end
            ST_MUL_EARN: state_next = ST_EARN_GO;
            ST_EARN_GO:  state_next = ST_EARN_WAIT;
            ST_EARN_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_ADD_EARN;
                end
            end
            ST_ADD_EARN: state_next = ST_CMP_CAP;
            ST_CMP_CAP: begin
                priority if (status.cap_over) begin
                    state_next = ST_PUSH_ACC;
                end else if (status.credit_neg) begin
                    state_next = ST_MUL_DLO;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_DLO:  state_next = ST_MUL_DHI;
            ST_MUL_DHI:  state_next = ST_DSUM;
            ST_DSUM:     state_next = ST_SLEEP_GO;
            ST_SLEEP_GO: state_next = ST_SLEEP_WAIT;
            ST_SLEEP_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_SLEEP_SET;
                end
            end
            ST_SLEEP_SET: state_next = ST_PUSH_ACC;
            ST_PUSH_ACC:  state_next = ST_PUSH_ROT;
            ST_PUSH_ROT:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MUL_GAP_RATE;
        cmd.div_mode = DIV_EARN;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.in_load = s_valid;
            end
            ST_CHECK:  cmd.gap_load = 1'b1;
            ST_RESYNC: cmd.resync = 1'b1;
            ST_DEBIT:  cmd.debit = 1'b1;
            ST_MUL_EARN: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAP_RATE;
            end
            ST_EARN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_EARN;
            end
            ST_EARN_WAIT: cmd.div_mode = DIV_EARN;
            ST_ADD_EARN: begin
                cmd.add_earn = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_CAP;
            end
            ST_CMP_CAP: begin
                cmd.cap_load     = status.cap_over;
                cmd.deficit_load = 1'b1;
            end
            ST_MUL_DLO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEF_LO;
            end
            ST_MUL_DHI: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DEF_HI;
                cmd.dlo_save = 1'b1;
            end
            ST_DSUM: cmd.dsum = 1'b1;
            ST_SLEEP_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_SLEEP;
            end
            ST_SLEEP_WAIT: cmd.div_mode = DIV_SLEEP;
            ST_SLEEP_SET: begin
                cmd.sleep_set = 1'b1;
                cmd.div_mode  = DIV_SLEEP;
            end
            ST_PUSH_ACC: cmd.push_acc = 1'b1;
            ST_PUSH_ROT: cmd.slot_rotate = status.acc_over;
            ST_DONE:     cmd.out_load = out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

    // result valid: set on load, clear once the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hdl/bandwidth_limiter_window_stats.sv @@
// ----------------------------------------------------------------------------
// bandwidth_limiter_window_stats
// Token-bucket rate limiter with a one-second slot ring of window totals.
// ----------------------------------------------------------------------------
// One event at a time; next accept in the cycle after the result is loaded.
// The reciprocal earn division and the 32-step serial sleep division take the
// longest time within an event.
// Reset (aresetn, synchronous, active low) clears credit, last tick, window
// sums, accumulators and slot valid bits at once; no clearing pass.
module bandwidth_limiter_window_stats
    import bwl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [CFG_W-1:0]    pwdata,
    output logic [CFG_W-1:0]    prdata,
    output logic                pready,
    // events in
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [NOW_W-1:0]    s_now_us,
    input  logic [BYTES_W-1:0]  s_byte_count,
    // results out
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLEEP_W-1:0]  m_sleep_us,
    output logic [WTIME_W-1:0]  m_window_time,
    output logic [WBYTES_W-1:0] m_window_bytes,
    output logic [WSLEEP_W-1:0] m_window_sleep
);

    logic [CFG_W-1:0] rate_limit_reg;
    logic [CFG_W-1:0] backlog_limit_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    status_t          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_limit_reg    <= '0;
            backlog_limit_reg <= BACKLOG_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_RATE_LIMIT:    rate_limit_reg <= pwdata;
                REG_BACKLOG_LIMIT: backlog_limit_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RATE_LIMIT:    prdata = rate_limit_reg;
            REG_BACKLOG_LIMIT: prdata = backlog_limit_reg;
            default:           prdata = '0;
        endcase
    end

    bwl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bwl_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .rate_limit     (rate_limit_reg),
        .backlog_limit  (backlog_limit_reg),
        .s_now_us       (s_now_us),
        .s_byte_count   (s_byte_count),
        .m_sleep_us     (m_sleep_us),
        .m_window_time  (m_window_time),
        .m_window_bytes (m_window_bytes),
        .m_window_sleep (m_window_sleep)
    );

`ifndef ASSERT_OFF
    // one event at a time: input closes right after a transfer
    a_single_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an event is in progress");

    // short sleeps are dropped to zero
    a_sleep_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_sleep_us == '0) || (m_sleep_us > SLEEP_W'(MIN_SLEEP_US))))
        else $error("sleep reported at or below the minimum");

    // limiting disabled gives no sleep
    a_unlimited_no_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (rate_limit_reg == '0)) |-> (m_sleep_us == '0))
        else $error("sleep reported with limiting disabled");
`endif

endmodule
